// ===== rtl/mcru_pkg.sv =====
package mcru_pkg;

   localparam int DICE    = 5;
   localparam int SLOTS   = DICE + 5;
   localparam int SEPS    = 5;
   localparam int FACES   = 6;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 3;
   localparam int SUM_W   = 6;
   localparam int BINOM_W = 16;
   localparam int POS_W   = $clog2(SLOTS + 2);
   localparam int NIDX_W  = $clog2(SLOTS + 1);
   localparam int STEP_W  = $clog2(SEPS + 1);

   localparam logic KIND_RANK   = 1'b0;
   localparam logic KIND_UNRANK = 1'b1;

   typedef logic [SLOTS:0][SEPS:0][BINOM_W-1:0] binom_tab_type;

   // Pascal's triangle, built by additions only.
   function automatic binom_tab_type build_binom();
      binom_tab_type tab;
      tab = '0;
      for (int n = 0; n <= SLOTS; n++) begin
         tab[n][0] = BINOM_W'(1);
         for (int k = 1; k <= SEPS; k++) begin
            if (n > 0) begin
               tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
            end
         end
      end
      return tab;
   endfunction

   localparam binom_tab_type BINOM_TAB = build_binom();

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

// ===== rtl/mcru_ctrl.sv =====
module mcru_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mcru_pkg::status_type   status,
   output mcru_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import mcru_pkg::*;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (status.last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/mcru_datapath.sv =====
module mcru_datapath (
   input  logic                   clock,
   input  mcru_pkg::cmd_type      cmd,
   output mcru_pkg::status_type   status,
   input  logic                   req_kind,
   input  logic [7:0]             req_index_in,
   input  logic [2:0]             req_count_one,
   input  logic [2:0]             req_count_two,
   input  logic [2:0]             req_count_three,
   input  logic [2:0]             req_count_four,
   input  logic [2:0]             req_count_five,
   input  logic [2:0]             req_count_six,
   output logic [7:0]             rsp_index_out,
   output logic [2:0]             rsp_face_one,
   output logic [2:0]             rsp_face_two,
   output logic [2:0]             rsp_face_three,
   output logic [2:0]             rsp_face_four,
   output logic [2:0]             rsp_face_five,
   output logic [2:0]             rsp_face_six,
   output logic                   rsp_bad_input
);
   import mcru_pkg::*;

   logic                                kind_ff, kind_in;
   logic                                bad_ff, bad_in;
   logic [SEPS-1:0][COUNT_W-1:0]        cnt_ff, cnt_in;
   logic [INDEX_W-1:0]                  e_ff, e_in;
   logic [POS_W-1:0]                    ptr_ff, ptr_in;
   logic [STEP_W-1:0]                   i_ff, i_in;
   logic [BINOM_W-1:0]                  idx_ff, idx_in;
   logic [SEPS-1:0][POS_W-1:0]          pos_ff, pos_in;
   logic [INDEX_W-1:0]                  out_index_ff, out_index_in;
   logic [FACES-1:0][COUNT_W-1:0]       out_face_ff, out_face_in;
   logic                                out_bad_ff, out_bad_in;

   logic [SUM_W-1:0]                    count_sum;
   logic                                sum_bad;
   logic                                index_bad;
   logic [POS_W-1:0]                    rank_ptr;
   logic [POS_W-1:0]                    look_ptr;
   logic [POS_W-1:0]                    n_full;
   logic [NIDX_W-1:0]                   n_sel;
   logic [STEP_W-1:0]                   k_sel;
   logic [BINOM_W-1:0]                  binom_val;
   logic                                skip;
   logic [FACES-1:0][POS_W-1:0]         face_diff;

   assign count_sum = SUM_W'(req_count_one) + SUM_W'(req_count_two)
                    + SUM_W'(req_count_three) + SUM_W'(req_count_four)
                    + SUM_W'(req_count_five) + SUM_W'(req_count_six);
   assign sum_bad   = (count_sum != SUM_W'(DICE));
   assign index_bad = (BINOM_W'(req_index_in) >= BINOM_TAB[SLOTS][SEPS]);

   // Rank advances the separator by the next count; unrank probes the
   // current candidate position.
   assign rank_ptr  = ptr_ff + POS_W'(cnt_ff[0]) + POS_W'(1);
   assign look_ptr  = (kind_ff == KIND_RANK) ? rank_ptr : ptr_ff;
   assign n_full    = POS_W'(SLOTS) - look_ptr;
   assign n_sel     = n_full[NIDX_W-1:0];
   assign k_sel     = STEP_W'(SEPS) - i_ff;
   assign binom_val = BINOM_TAB[n_sel][k_sel];
   assign skip      = (ptr_ff < POS_W'(SLOTS)) && (binom_val > BINOM_W'(e_ff));

   assign status.last = bad_ff || (i_ff == STEP_W'(SEPS));

   // The newest separator sits at index 0, the first one at the top.
   always_comb begin
      face_diff[0] = pos_ff[SEPS-1] - POS_W'(1);
      for (int f = 1; f < SEPS; f++) begin
         face_diff[f] = pos_ff[SEPS-1-f] - pos_ff[SEPS-f] - POS_W'(1);
      end
      face_diff[FACES-1] = POS_W'(SLOTS) - pos_ff[0];
   end

   always_comb begin
      kind_in      = kind_ff;
      bad_in       = bad_ff;
      cnt_in       = cnt_ff;
      e_in         = e_ff;
      ptr_in       = ptr_ff;
      i_in         = i_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      out_index_in = out_index_ff;
      out_face_in  = out_face_ff;
      out_bad_in   = out_bad_ff;

      if (cmd.load) begin
         kind_in   = req_kind;
         bad_in    = (req_kind == KIND_RANK) ? sum_bad : index_bad;
         cnt_in[0] = req_count_one;
         cnt_in[1] = req_count_two;
         cnt_in[2] = req_count_three;
         cnt_in[3] = req_count_four;
         cnt_in[4] = req_count_five;
         e_in      = req_index_in;
         ptr_in    = (req_kind == KIND_RANK) ? '0 : POS_W'(1);
         i_in      = '0;
         idx_in    = '0;
      end else if (cmd.step) begin
         if (kind_ff == KIND_RANK) begin
            ptr_in = rank_ptr;
            idx_in = idx_ff + binom_val;
            cnt_in = {COUNT_W'(0), cnt_ff[SEPS-1:1]};
            i_in   = i_ff + STEP_W'(1);
         end else if (skip) begin
            ptr_in = ptr_ff + POS_W'(1);
         end else begin
            pos_in = {pos_ff[SEPS-2:0], ptr_ff};
            e_in   = e_ff - binom_val[INDEX_W-1:0];
            ptr_in = ptr_ff + POS_W'(1);
            i_in   = i_ff + STEP_W'(1);
         end
      end

      if (cmd.finish) begin
         out_bad_in   = bad_ff;
         out_index_in = (kind_ff == KIND_RANK && !bad_ff) ? idx_ff[INDEX_W-1:0] : '0;
         for (int f = 0; f < FACES; f++) begin
            out_face_in[f] = (kind_ff == KIND_UNRANK && !bad_ff) ?
                             face_diff[f][COUNT_W-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      bad_ff       <= bad_in;
      cnt_ff       <= cnt_in;
      e_ff         <= e_in;
      ptr_ff       <= ptr_in;
      i_ff         <= i_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      out_index_ff <= out_index_in;
      out_face_ff  <= out_face_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_index_out  = out_index_ff;
   assign rsp_face_one   = out_face_ff[0];
   assign rsp_face_two   = out_face_ff[1];
   assign rsp_face_three = out_face_ff[2];
   assign rsp_face_four  = out_face_ff[3];
   assign rsp_face_five  = out_face_ff[4];
   assign rsp_face_six   = out_face_ff[5];
   assign rsp_bad_input  = out_bad_ff;

endmodule

// ===== rtl/multiset_combinadic_rank_unrank.sv =====
// Channel   Handshake               Beat
// request   start high, busy low    req_kind, req_index_in, req_count_one..six
// response  rsp_strobe, one cycle   rsp_index_out, rsp_face_one..six, rsp_bad_input
//
// Rank steps once per separator through the binomial table, then registers the beat.
// Unrank's downward search moves one candidate position per cycle. A rejected request
// finishes without any step. The response beat shows in the same cycle that busy falls.
// Reset is synchronous and clears the sequencer and the strobe. The receiver cannot
// stall; a beat is never held.
module multiset_combinadic_rank_unrank (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [7:0]  req_index_in,
   input  logic [2:0]  req_count_one,
   input  logic [2:0]  req_count_two,
   input  logic [2:0]  req_count_three,
   input  logic [2:0]  req_count_four,
   input  logic [2:0]  req_count_five,
   input  logic [2:0]  req_count_six,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_index_out,
   output logic [2:0]  rsp_face_one,
   output logic [2:0]  rsp_face_two,
   output logic [2:0]  rsp_face_three,
   output logic [2:0]  rsp_face_four,
   output logic [2:0]  rsp_face_five,
   output logic [2:0]  rsp_face_six,
   output logic        rsp_bad_input
);
   import mcru_pkg::*;

   cmd_type    cmd;
   status_type status;

   mcru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mcru_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_index_in    (req_index_in),
      .req_count_one   (req_count_one),
      .req_count_two   (req_count_two),
      .req_count_three (req_count_three),
      .req_count_four  (req_count_four),
      .req_count_five  (req_count_five),
      .req_count_six   (req_count_six),
      .rsp_index_out   (rsp_index_out),
      .rsp_face_one    (rsp_face_one),
      .rsp_face_two    (rsp_face_two),
      .rsp_face_three  (rsp_face_three),
      .rsp_face_four   (rsp_face_four),
      .rsp_face_five   (rsp_face_five),
      .rsp_face_six    (rsp_face_six),
      .rsp_bad_input   (rsp_bad_input)
   );

endmodule

// ===== rtl/mcru_checker.sv =====
module mcru_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_index_out,
   input logic [2:0] rsp_face_one,
   input logic [2:0] rsp_face_two,
   input logic [2:0] rsp_face_three,
   input logic [2:0] rsp_face_four,
   input logic [2:0] rsp_face_five,
   input logic [2:0] rsp_face_six,
   input logic       rsp_bad_input
);

   // An accepted request keeps the block busy until its beat is ready.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // Every end of work produces exactly one beat.
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a response beat");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response beat while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // A rejected request carries all-zero fields.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bad_input |-> rsp_index_out == 8'd0 && rsp_face_one == 3'd0
         && rsp_face_two == 3'd0 && rsp_face_three == 3'd0 && rsp_face_four == 3'd0
         && rsp_face_five == 3'd0 && rsp_face_six == 3'd0)
      else $error("rejected request with nonzero fields");

endmodule

bind multiset_combinadic_rank_unrank mcru_checker u_mcru_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_index_out  (rsp_index_out),
   .rsp_face_one   (rsp_face_one),
   .rsp_face_two   (rsp_face_two),
   .rsp_face_three (rsp_face_three),
   .rsp_face_four  (rsp_face_four),
   .rsp_face_five  (rsp_face_five),
   .rsp_face_six   (rsp_face_six),
   .rsp_bad_input  (rsp_bad_input)
);

// ===== tb/tb_multiset_combinadic_rank_unrank.sv =====
`timescale 1ns / 1ps

module tb_multiset_combinadic_rank_unrank;
   import mcru_pkg::*;

   typedef struct packed {
      logic                          kind;
      logic [INDEX_W-1:0]            index_in;
      logic [0:FACES-1][COUNT_W-1:0] count;
   } dice_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]            index_out;
      logic [0:FACES-1][COUNT_W-1:0] face;
      logic                          bad;
   } dice_result_type;

   typedef struct packed {
      dice_req_type    req;
      logic            typed;
      dice_result_type want;
   } directed_row_type;

   localparam int N_DIRECTED  = 22;
   localparam int N_RANDOM    = 550;
   localparam int DRAIN_TICKS = 24;

   localparam dice_result_type UNTYPED  = '0;
   localparam dice_result_type REJECTED = '{8'd0, 18'd0, 1'b1};

   // Rows with typed expectations cover the extremes and the rejections; the rest
   // are checked against the predictor.
   localparam directed_row_type DIRECTED_ROWS [0:N_DIRECTED-1] = '{
      '{'{KIND_RANK,   8'd0,   {3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1,
        '{8'd0,   18'd0, 1'b0}},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd5}}, 1'b1,
        '{8'd251, 18'd0, 1'b0}},
      '{'{KIND_UNRANK, 8'd0,   {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1,
        '{8'd0, {3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}, 1'b0}},
      '{'{KIND_UNRANK, 8'd251, {3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}}, 1'b1,
        '{8'd0, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd5}, 1'b0}},
      '{'{KIND_UNRANK, 8'd252, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1, REJECTED},
      '{'{KIND_UNRANK, 8'd255, {3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}}, 1'b1, REJECTED},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1, REJECTED},
      '{'{KIND_RANK,   8'd255, {3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}}, 1'b1, REJECTED},
      '{'{KIND_RANK,   8'd0,   {3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1, REJECTED},
      '{'{KIND_RANK,   8'd0,   {3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b1, REJECTED},
      '{'{KIND_RANK,   8'hAA,  {3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'd0,   {3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'h55,  {3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1}}, 1'b0, UNTYPED},
      '{'{KIND_RANK,   8'd0,   {3'd2, 3'd1, 3'd0, 3'd0, 3'd2, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_UNRANK, 8'd1,   {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_UNRANK, 8'd125, {3'd5, 3'd2, 3'd5, 3'd2, 3'd5, 3'd2}}, 1'b0, UNTYPED},
      '{'{KIND_UNRANK, 8'd126, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_UNRANK, 8'd128, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED},
      '{'{KIND_UNRANK, 8'd250, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}}, 1'b0, UNTYPED}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_kind;
   logic [7:0]          req_index_in;
   logic [2:0]          req_count_one;
   logic [2:0]          req_count_two;
   logic [2:0]          req_count_three;
   logic [2:0]          req_count_four;
   logic [2:0]          req_count_five;
   logic [2:0]          req_count_six;
   logic                rsp_strobe;
   logic [7:0]          rsp_index_out;
   logic [2:0]          rsp_face_one;
   logic [2:0]          rsp_face_two;
   logic [2:0]          rsp_face_three;
   logic [2:0]          rsp_face_four;
   logic [2:0]          rsp_face_five;
   logic [2:0]          rsp_face_six;
   logic                rsp_bad_input;

   dice_result_type     expected_outcomes [$];
   int                  err_count = 0;

   multiset_combinadic_rank_unrank dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_index_in    (req_index_in),
      .req_count_one   (req_count_one),
      .req_count_two   (req_count_two),
      .req_count_three (req_count_three),
      .req_count_four  (req_count_four),
      .req_count_five  (req_count_five),
      .req_count_six   (req_count_six),
      .rsp_strobe      (rsp_strobe),
      .rsp_index_out   (rsp_index_out),
      .rsp_face_one    (rsp_face_one),
      .rsp_face_two    (rsp_face_two),
      .rsp_face_three  (rsp_face_three),
      .rsp_face_four   (rsp_face_four),
      .rsp_face_five   (rsp_face_five),
      .rsp_face_six    (rsp_face_six),
      .rsp_bad_input   (rsp_bad_input)
   );

   always #10 clock = ~clock;

   function automatic int choose(int n, int k);
      int c = 1;
      if (n < 0 || n < k) return 0;
      if (2 * k > n) k = n - k;
      for (int i = 0; i < k; i++) c = c * (n - i) / (i + 1);
      return c;
   endfunction

   // Stars and bars: separator p_i sits at count_one + ... + count_i + i.
   function automatic dice_result_type predict_outcome(dice_req_type req);
      dice_result_type res;
      int              sum;
      int              sep;
      int              idx;
      int              remain;
      int              cand;
      int              sep_pos [SEPS];
      res = '0;
      if (req.kind == KIND_RANK) begin
         sum = 0;
         for (int f = 0; f < FACES; f++) sum += int'(req.count[f]);
         if (sum != DICE) begin
            res.bad = 1'b1;
         end else begin
            sep = 0;
            idx = 0;
            for (int i = 0; i < SEPS; i++) begin
               sep += int'(req.count[i]) + 1;
               idx += choose(SLOTS - sep, SEPS - i);
            end
            res.index_out = INDEX_W'(idx);
         end
      end else begin
         remain = int'(req.index_in);
         if (remain >= choose(SLOTS, SEPS)) begin
            res.bad = 1'b1;
         end else begin
            cand = 1;
            for (int i = 0; i < SEPS; i++) begin
               while (cand < SLOTS && choose(SLOTS - cand, SEPS - i) > remain) cand++;
               sep_pos[i] = cand;
               remain -= choose(SLOTS - cand, SEPS - i);
               cand++;
            end
            res.face[0] = COUNT_W'(sep_pos[0] - 1);
            for (int i = 1; i < SEPS; i++)
               res.face[i] = COUNT_W'(sep_pos[i] - sep_pos[i-1] - 1);
            res.face[FACES-1] = COUNT_W'(SLOTS - sep_pos[SEPS-1]);
         end
      end
      return res;
   endfunction

   // Mostly well-formed requests with random content; the rest are rejects and noise.
   function automatic dice_req_type random_request();
      dice_req_type r;
      int           pick;
      int           f;
      pick       = $urandom_range(0, 9);
      r.index_in = INDEX_W'($urandom);
      r.count    = 18'($urandom);
      r.kind     = KIND_UNRANK;
      if (pick < 4) begin
         r.kind  = KIND_RANK;
         r.count = '0;
         repeat (DICE) begin
            f = $urandom_range(0, FACES - 1);
            r.count[f] = r.count[f] + 1'b1;
         end
      end else if (pick < 8) begin
         r.index_in = INDEX_W'($urandom_range(0, choose(SLOTS, SEPS) - 1));
      end else if (pick == 8) begin
         r.kind = KIND_RANK;
      end else begin
         r.index_in = INDEX_W'($urandom_range(choose(SLOTS, SEPS), 255));
      end
      return r;
   endfunction

   // Holds start high until the beat is taken at an edge where busy is low.
   task automatic send_beat(input dice_req_type item, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind        <= item.kind;
      req_index_in    <= item.index_in;
      req_count_one   <= item.count[0];
      req_count_two   <= item.count[1];
      req_count_three <= item.count[2];
      req_count_four  <= item.count[3];
      req_count_five  <= item.count[4];
      req_count_six   <= item.count[5];
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      dice_req_type item;
      bit           burst;
      int           gap;
      burst           = 1'b0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= KIND_RANK;
      req_index_in    <= '0;
      req_count_one   <= '0;
      req_count_two   <= '0;
      req_count_three <= '0;
      req_count_four  <= '0;
      req_count_five  <= '0;
      req_count_six   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_beat(DIRECTED_ROWS[i].req, $urandom_range(0, 7));
         if (DIRECTED_ROWS[i].typed)
            expected_outcomes.push_back(DIRECTED_ROWS[i].want);
         else
            expected_outcomes.push_back(predict_outcome(DIRECTED_ROWS[i].req));
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 19) == 0) burst = !burst;
         gap  = burst ? 0 : $urandom_range(0, 7);
         item = random_request();
         send_beat(item, gap);
         expected_outcomes.push_back(predict_outcome(item));
      end
      start <= 1'b0;

      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   always @(posedge clock) begin
      dice_result_type got;
      dice_result_type want;
      got = {rsp_index_out, rsp_face_one, rsp_face_two, rsp_face_three,
             rsp_face_four, rsp_face_five, rsp_face_six, rsp_bad_input};
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result beat, index_out %0d bad_input %0b",
                     $time, got.index_out, got.bad);
            err_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got.index_out !== want.index_out) begin
               $display("%0t: index_out expected %0d actual %0d",
                        $time, want.index_out, got.index_out);
               err_count++;
            end
            for (int f = 0; f < FACES; f++) begin
               if (got.face[f] !== want.face[f]) begin
                  $display("%0t: face %0d count expected %0d actual %0d",
                           $time, f + 1, want.face[f], got.face[f]);
                  err_count++;
               end
            end
            if (got.bad !== want.bad) begin
               $display("%0t: bad_input expected %0b actual %0b",
                        $time, want.bad, got.bad);
               err_count++;
            end
         end
      end
   end

   // A correct run needs well under a millisecond.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== multiset_combinadic_rank_unrank.f =====
rtl/mcru_pkg.sv
rtl/mcru_ctrl.sv
rtl/mcru_datapath.sv
rtl/multiset_combinadic_rank_unrank.sv
rtl/mcru_checker.sv
tb/tb_multiset_combinadic_rank_unrank.sv
